>>> src/swvc_pkg.sv
`timescale 1ns / 1ps
// Package for the suspension wheel valve controller.
// Holds command, fault and register index codes, config and result types.
package swvc_pkg;

	localparam int LEVEL_BITS_DEF = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [7:0] LEVEL_MAX_RST = 8'd255;
	localparam logic [7:0] LEVEL_MIN_RST = 8'd0;
	localparam logic [7:0] DEAD_BAND_RST = 8'd4;
	localparam logic [7:0] DEV_MIN_RST = 8'd4;
	localparam logic [7:0] DEF_TIMEOUT_RST = 8'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEVEL_MAX = 3'd0,
		CFG_LEVEL_MIN = 3'd1,
		CFG_DEAD_BAND = 3'd2,
		CFG_DEV_MIN = 3'd3,
		CFG_DEF_TIMEOUT = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ACT_UP = 2'd0,
		ACT_DOWN = 2'd1,
		ACT_STOP = 2'd2,
		ACT_UNKNOWN = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		FLT_NONE = 2'd0,
		FLT_NO_SAMPLE = 2'd1,
		FLT_NO_AVG = 2'd2,
		FLT_UNKNOWN_CMD = 2'd3
	} fault_t;

	typedef struct packed {
		logic [7:0] level_max;
		logic [7:0] level_min;
		logic [7:0] dead_band;
		logic [7:0] deviation_min;
		logic [7:0] default_timeout_sec;
	} cfg_t;

	typedef struct packed {
		logic   up_valve;
		logic   down_valve;
		logic   busy_res;
		fault_t fault;
	} res_t;

endpackage

>>> src/swvc_if.sv
`timescale 1ns / 1ps
// Channel interfaces: command item in, result item out, config writes.
// Depends on swvc_pkg for default widths.
interface swvc_cmd_if #(
	parameter int LEVEL_BITS = swvc_pkg::LEVEL_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic                  func;
	logic [1:0]            cmd_kind;
	logic                  has_target;
	logic [LEVEL_BITS-1:0] target_level;
	logic                  has_timeout;
	logic [7:0]            timeout_sec;
	logic                  sample_valid;
	logic [LEVEL_BITS-1:0] level_sample;
	logic                  delta_valid;
	logic [7:0]            avg_delta;
	logic                  second_tick;

	modport source (
		output valid, func, cmd_kind, has_target, target_level, has_timeout, timeout_sec,
		output sample_valid, level_sample, delta_valid, avg_delta, second_tick,
		input  ready
	);
	modport sink (
		input  valid, func, cmd_kind, has_target, target_level, has_timeout, timeout_sec,
		input  sample_valid, level_sample, delta_valid, avg_delta, second_tick,
		output ready
	);
endinterface

interface swvc_res_if;
	logic       valid;
	logic       ready;
	logic       up_valve;
	logic       down_valve;
	logic       busy_res;
	logic [1:0] fault;

	modport source (output valid, up_valve, down_valve, busy_res, fault, input ready);
	modport sink (input valid, up_valve, down_valve, busy_res, fault, output ready);
endinterface

interface swvc_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [swvc_pkg::CFG_IDX_W-1:0]      index;
	logic [swvc_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> src/swvc_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file: limits, dead band, deviation minimum, timeout.
// Depends on swvc_pkg and swvc_cfg_if.
module swvc_cfg_regs (
	input  logic             clk,
	input  logic             arst_n,
	swvc_cfg_if.sink         cfg,
	output swvc_pkg::cfg_t   regs
);
	import swvc_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.level_max <= LEVEL_MAX_RST;
			regs_q.level_min <= LEVEL_MIN_RST;
			regs_q.dead_band <= DEAD_BAND_RST;
			regs_q.deviation_min <= DEV_MIN_RST;
			regs_q.default_timeout_sec <= DEF_TIMEOUT_RST;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_LEVEL_MAX:   regs_q.level_max <= cfg.data;
				CFG_LEVEL_MIN:   regs_q.level_min <= cfg.data;
				CFG_DEAD_BAND:   regs_q.dead_band <= cfg.data;
				CFG_DEV_MIN:     regs_q.deviation_min <= cfg.data;
				CFG_DEF_TIMEOUT: regs_q.default_timeout_sec <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

>>> src/swvc_ctrl.sv
`timescale 1ns / 1ps
// Wheel control state and per-item decision logic: command load, timer,
// auto/manual drive, stop handling. Depends on swvc_pkg.
module swvc_ctrl #(
	parameter int LEVEL_BITS = swvc_pkg::LEVEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  swvc_pkg::cfg_t        cfg,
	input  logic                  func,
	input  logic [1:0]            cmd_kind,
	input  logic                  has_target,
	input  logic [LEVEL_BITS-1:0] target_level,
	input  logic                  has_timeout,
	input  logic [7:0]            timeout_sec,
	input  logic                  sample_valid,
	input  logic [LEVEL_BITS-1:0] level_sample,
	input  logic                  delta_valid,
	input  logic [7:0]            avg_delta,
	input  logic                  second_tick,
	output swvc_pkg::res_t        res
);
	import swvc_pkg::*;

	logic                  running_q;
	act_t                  action_q;
	logic [LEVEL_BITS-1:0] goal_q;
	logic [7:0]            elapsed_q;
	logic [7:0]            limit_q;
	logic [1:0]            valve_q;

	logic                  run;
	act_t                  act;
	logic [LEVEL_BITS-1:0] goal;
	logic [7:0]            el;
	logic [7:0]            lim;
	logic [1:0]            valve;
	fault_t                flt;
	logic                  skip;
	logic                  chk;

	logic [LEVEL_BITS-1:0] goal_sel;
	logic [LEVEL_BITS-1:0] db;
	logic [LEVEL_BITS-1:0] lo;
	logic [LEVEL_BITS:0]   hi;
	logic                  allow_up;
	logic                  allow_down;

	assign goal_sel = (func && has_target) ? target_level : goal_q;
	assign db = LEVEL_BITS'(cfg.dead_band);
	assign lo = (goal_sel > db) ? goal_sel - db : '0;
	assign hi = {1'b0, goal_sel} + {1'b0, db};
	assign allow_up = level_sample < LEVEL_BITS'(cfg.level_max);
	assign allow_down = level_sample > LEVEL_BITS'(cfg.level_min);

	always_comb begin
		run = running_q;
		act = action_q;
		goal = goal_q;
		el = elapsed_q;
		lim = limit_q;
		valve = valve_q;
		flt = FLT_NONE;
		skip = 1'b0;
		chk = 1'b1;
		if (func) begin
			run = 1'b1;
			el = '0;
			act = act_t'(cmd_kind);
			lim = has_timeout ? timeout_sec : cfg.default_timeout_sec;
			goal = goal_sel;
			if (act == ACT_UNKNOWN) begin
				skip = 1'b1;
				flt = FLT_UNKNOWN_CMD;
			end
		end else if (!running_q) begin
			skip = 1'b1;
		end else if (second_tick && el != 8'hFF) begin
			el = el + 8'd1;
		end
		if (!skip) begin
			if (!sample_valid) begin
				run = 1'b0;
				flt = FLT_NO_SAMPLE;
			end else begin
				if (goal != '0) begin
					if (!delta_valid) begin
						run = 1'b0;
						flt = FLT_NO_AVG;
						chk = 1'b0;
					end else if (avg_delta < cfg.deviation_min) begin
						run = 1'b0;
					end else if (level_sample < lo && allow_up) begin
						act = ACT_UP;
					end else if ({1'b0, level_sample} > hi && allow_down) begin
						act = ACT_DOWN;
					end else begin
						act = ACT_STOP;
					end
				end else begin
					if (act == ACT_UP && !allow_up) act = ACT_STOP;
					if (act == ACT_DOWN && !allow_down) act = ACT_STOP;
				end
				if (chk && run) run = el < lim;
			end
			case (act)
				ACT_UP:   valve = 2'b01;
				ACT_DOWN: valve = 2'b10;
				ACT_STOP: valve = 2'b00;
				default: ;
			endcase
			if (!run) begin
				act = ACT_UNKNOWN;
				goal = '0;
				el = '0;
				valve = 2'b00;
			end
		end
	end

	assign res.up_valve = valve[0];
	assign res.down_valve = valve[1];
	assign res.busy_res = run;
	assign res.fault = flt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			action_q <= ACT_UNKNOWN;
			goal_q <= '0;
			elapsed_q <= '0;
			limit_q <= '0;
			valve_q <= 2'b00;
		end else if (step) begin
			running_q <= run;
			action_q <= act;
			goal_q <= goal;
			elapsed_q <= el;
			limit_q <= lim;
			valve_q <= valve;
		end
	end

`ifndef SYNTHESIS
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |-> (action_q == ACT_UNKNOWN && goal_q == '0 && elapsed_q == '0
			&& valve_q == 2'b00))
		else $error("idle wheel holds stale command state");

	a_valves_excl: assert property (@(posedge clk) disable iff (!arst_n)
		valve_q != 2'b11)
		else $error("both valves open");

	a_fault_stops: assert property (@(posedge clk) disable iff (!arst_n)
		step && (res.fault == FLT_NO_SAMPLE || res.fault == FLT_NO_AVG) |-> !res.busy_res)
		else $error("wheel keeps running after a missing input");

	a_timer_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(elapsed_q) && $stable(running_q))
		else $error("control state moved without an item");
`endif

endmodule

>>> src/suspension_wheel_valve_control.sv
`timescale 1ns / 1ps
// Air-suspension wheel valve controller, top level.
// An accepted item passes an input register, then a result register, before its result is valid.
// One item per cycle while res.ready allows; the decision logic is a single pass of compares.
// Reset (arst_n low, async): wheel idle, valves closed, config registers to defaults.
// Depends on swvc_pkg, swvc_if, swvc_cfg_regs, swvc_ctrl.
module suspension_wheel_valve_control #(
	parameter int LEVEL_BITS = swvc_pkg::LEVEL_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	swvc_cmd_if.sink   cmd,
	swvc_res_if.source res,
	swvc_cfg_if.sink   cfg
);
	import swvc_pkg::*;

	logic                  valid_s1;
	logic                  func_s1;
	logic [1:0]            cmd_kind_s1;
	logic                  has_target_s1;
	logic [LEVEL_BITS-1:0] target_level_s1;
	logic                  has_timeout_s1;
	logic [7:0]            timeout_sec_s1;
	logic                  sample_valid_s1;
	logic [LEVEL_BITS-1:0] level_sample_s1;
	logic                  delta_valid_s1;
	logic [7:0]            avg_delta_s1;
	logic                  second_tick_s1;

	logic                  res_valid_q;
	res_t                  res_q;

	cfg_t                  regs;
	res_t                  res_c;
	logic                  adv;
	logic                  step;

	assign adv = !res_valid_q || res.ready;
	assign step = valid_s1 && adv;
	assign cmd.ready = !valid_s1 || adv;

	swvc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	swvc_ctrl #(.LEVEL_BITS(LEVEL_BITS)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.cfg          (regs),
		.func         (func_s1),
		.cmd_kind     (cmd_kind_s1),
		.has_target   (has_target_s1),
		.target_level (target_level_s1),
		.has_timeout  (has_timeout_s1),
		.timeout_sec  (timeout_sec_s1),
		.sample_valid (sample_valid_s1),
		.level_sample (level_sample_s1),
		.delta_valid  (delta_valid_s1),
		.avg_delta    (avg_delta_s1),
		.second_tick  (second_tick_s1),
		.res          (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.ready) valid_s1 <= cmd.valid;
			if (adv) res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			func_s1 <= cmd.func;
			cmd_kind_s1 <= cmd.cmd_kind;
			has_target_s1 <= cmd.has_target;
			target_level_s1 <= cmd.target_level;
			has_timeout_s1 <= cmd.has_timeout;
			timeout_sec_s1 <= cmd.timeout_sec;
			sample_valid_s1 <= cmd.sample_valid;
			level_sample_s1 <= cmd.level_sample;
			delta_valid_s1 <= cmd.delta_valid;
			avg_delta_s1 <= cmd.avg_delta;
			second_tick_s1 <= cmd.second_tick;
		end
		if (step) res_q <= res_c;
	end

	assign res.valid = res_valid_q;
	assign res.up_valve = res_q.up_valve;
	assign res.down_valve = res_q.down_valve;
	assign res.busy_res = res_q.busy_res;
	assign res.fault = res_q.fault;

endmodule

>>> verif/suspension_wheel_valve_control_test.sv
`timescale 1ns / 1ps
// Testbench for the suspension wheel valve controller: directed control cycles, then random
// command runs under several register settings, checked against an in-bench valve predictor.
// Depends on swvc_pkg, swvc_if and the suspension_wheel_valve_control RTL.
module suspension_wheel_valve_control_test;
	import swvc_pkg::*;

	typedef struct {
		logic       func;
		logic [1:0] cmd_kind;
		logic       has_target;
		logic [7:0] target_level;
		logic       has_timeout;
		logic [7:0] timeout_sec;
		logic       sample_valid;
		logic [7:0] level_sample;
		logic       delta_valid;
		logic [7:0] avg_delta;
		logic       second_tick;
	} wheel_item_t;

	typedef struct {
		wheel_item_t it;
		bit          typed;
		res_t        want;
	} step_row_t;

	typedef enum {RX_FLOW, RX_COIN, RX_CHOKE} rx_mode_t;

	logic clk;
	logic arst_n;

	swvc_cmd_if #(.LEVEL_BITS(LEVEL_BITS_DEF)) cmd_ch ();
	swvc_res_if res_ch ();
	swvc_cfg_if cfg_ch ();

	suspension_wheel_valve_control #(.LEVEL_BITS(LEVEL_BITS_DEF)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// predictor copy of the wheel and its registers
	cfg_t       regs;
	logic       wheel_running;
	act_t       wheel_action;
	logic [7:0] wheel_goal;
	logic [7:0] run_secs;
	logic [7:0] run_limit;
	logic [1:0] valve_bits;

	res_t pending_res[$];
	int   errors = 0;
	int   n_items = 0;
	int   n_cmds = 0;
	int   n_checked = 0;
	int   n_faulted = 0;
	int   burst_left = 8;
	bit   hold_off_req = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("timeout: results still outstanding: %0d", pending_res.size());
		$display("FAIL");
		$finish;
	end

	function automatic res_t predict_valves(input wheel_item_t c);
		res_t       r;
		fault_t     flt;
		logic       skip;
		logic       up_ok;
		logic       down_ok;
		logic       timer_on;
		logic [8:0] lo;
		logic [8:0] hi;
		flt = FLT_NONE;
		skip = 1'b0;
		if (c.func) begin
			wheel_running = 1'b1;
			run_secs = 8'd0;
			wheel_action = act_t'(c.cmd_kind);
			run_limit = c.has_timeout ? c.timeout_sec : regs.default_timeout_sec;
			if (c.has_target) wheel_goal = c.target_level;
			if (c.cmd_kind == ACT_UNKNOWN) begin
				skip = 1'b1;
				flt = FLT_UNKNOWN_CMD;
			end
		end else if (!wheel_running) begin
			skip = 1'b1;
		end else if (c.second_tick && run_secs != 8'd255) begin
			run_secs = run_secs + 8'd1;
		end
		if (!skip) begin
			if (!c.sample_valid) begin
				wheel_running = 1'b0;
				flt = FLT_NO_SAMPLE;
			end else begin
				up_ok = c.level_sample < regs.level_max;
				down_ok = c.level_sample > regs.level_min;
				timer_on = 1'b1;
				if (wheel_goal != 8'd0) begin
					if (!c.delta_valid) begin
						wheel_running = 1'b0;
						flt = FLT_NO_AVG;
						timer_on = 1'b0;
					end else if (c.avg_delta < regs.deviation_min) begin
						wheel_running = 1'b0;
					end else begin
						lo = (wheel_goal > regs.dead_band) ?
							{1'b0, wheel_goal - regs.dead_band} : 9'd0;
						hi = {1'b0, wheel_goal} + {1'b0, regs.dead_band};
						if ({1'b0, c.level_sample} < lo && up_ok) wheel_action = ACT_UP;
						else if ({1'b0, c.level_sample} > hi && down_ok) wheel_action = ACT_DOWN;
						else wheel_action = ACT_STOP;
					end
				end else begin
					if (wheel_action == ACT_UP && !up_ok) wheel_action = ACT_STOP;
					if (wheel_action == ACT_DOWN && !down_ok) wheel_action = ACT_STOP;
				end
				if (timer_on && wheel_running) wheel_running = run_secs < run_limit;
			end
			case (wheel_action)
				ACT_UP: valve_bits = 2'b01;
				ACT_DOWN: valve_bits = 2'b10;
				ACT_STOP: valve_bits = 2'b00;
				default: ;
			endcase
			if (!wheel_running) begin
				wheel_action = ACT_UNKNOWN;
				wheel_goal = 8'd0;
				run_secs = 8'd0;
				valve_bits = 2'b00;
			end
		end
		r.up_valve = valve_bits[0];
		r.down_valve = valve_bits[1];
		r.busy_res = wheel_running;
		r.fault = flt;
		return r;
	endfunction

	function automatic wheel_item_t cyc(input logic f, input logic [1:0] k, input logic ht,
			input logic [7:0] tgt, input logic hto, input logic [7:0] tmo, input logic sv,
			input logic [7:0] lvl, input logic dv, input logic [7:0] avg, input logic tick);
		wheel_item_t c;
		c = '{f, k, ht, tgt, hto, tmo, sv, lvl, dv, avg, tick};
		return c;
	endfunction

	// sensor-biased plain cycle; command fields carry junk that a plain cycle ignores
	function automatic wheel_item_t rand_cycle(input int aim);
		wheel_item_t c;
		int          lvl;
		c.func = 1'b0;
		c.cmd_kind = 2'($urandom_range(0, 3));
		c.has_target = 1'($urandom);
		c.target_level = 8'($urandom);
		c.has_timeout = 1'($urandom);
		c.timeout_sec = 8'($urandom);
		c.sample_valid = ($urandom_range(0, 31) != 0);
		lvl = aim + int'($urandom_range(0, 64)) - 32;
		if ($urandom_range(0, 3) == 0) lvl = $urandom_range(0, 255);
		c.level_sample = (lvl < 0) ? 8'd0 : (lvl > 255) ? 8'd255 : 8'(lvl);
		c.delta_valid = ($urandom_range(0, 31) != 0);
		c.avg_delta = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 24));
		c.second_tick = ($urandom_range(0, 2) == 0);
		return c;
	endfunction

	task automatic offer_cycle(input wheel_item_t c, input bit typed, input res_t want);
		res_t guess;
		bit   took;
		cmd_ch.valid <= 1'b1;
		cmd_ch.func <= c.func;
		cmd_ch.cmd_kind <= c.cmd_kind;
		cmd_ch.has_target <= c.has_target;
		cmd_ch.target_level <= c.target_level;
		cmd_ch.has_timeout <= c.has_timeout;
		cmd_ch.timeout_sec <= c.timeout_sec;
		cmd_ch.sample_valid <= c.sample_valid;
		cmd_ch.level_sample <= c.level_sample;
		cmd_ch.delta_valid <= c.delta_valid;
		cmd_ch.avg_delta <= c.avg_delta;
		cmd_ch.second_tick <= c.second_tick;
		took = 1'b0;
		while (!took) begin
			@(negedge clk);
			took = cmd_ch.ready;
			@(posedge clk);
		end
		guess = predict_valves(c);
		pending_res.push_back(typed ? want : guess);
		n_items++;
		if (c.func) n_cmds++;
		burst_left--;
		if (burst_left <= 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) :
				$urandom_range(1, 16);
		end
	endtask

	task automatic settle();
		cmd_ch.valid <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_regs(input cfg_t v);
		cfg_idx_t idx;
		bit       took;
		idx = idx.first();
		do begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx;
			case (idx)
				CFG_LEVEL_MAX: cfg_ch.data <= v.level_max;
				CFG_LEVEL_MIN: cfg_ch.data <= v.level_min;
				CFG_DEAD_BAND: cfg_ch.data <= v.dead_band;
				CFG_DEV_MIN: cfg_ch.data <= v.deviation_min;
				CFG_DEF_TIMEOUT: cfg_ch.data <= v.default_timeout_sec;
				default: cfg_ch.data <= '0;
			endcase
			took = 1'b0;
			while (!took) begin
				@(negedge clk);
				took = cfg_ch.ready;
				@(posedge clk);
			end
			idx = idx.next();
		end while (idx != idx.first());
		cfg_ch.valid <= 1'b0;
		regs = v;
	endtask

	task automatic report_field(input string name, input logic [1:0] want, input logic [1:0] seen);
		errors++;
		$display("%0t: %s expected %0d got %0d", $time, name, want, seen);
	endtask

	task automatic check_result(input res_t seen);
		res_t want;
		n_checked++;
		if (seen.fault != FLT_NONE) n_faulted++;
		if (pending_res.size() == 0) begin
			errors++;
			$display("%0t: unexpected result %p", $time, seen);
		end else begin
			want = pending_res.pop_front();
			if (seen.up_valve !== want.up_valve)
				report_field("up_valve", 2'(want.up_valve), 2'(seen.up_valve));
			if (seen.down_valve !== want.down_valve)
				report_field("down_valve", 2'(want.down_valve), 2'(seen.down_valve));
			if (seen.busy_res !== want.busy_res)
				report_field("busy_res", 2'(want.busy_res), 2'(seen.busy_res));
			if (seen.fault !== want.fault)
				report_field("fault", want.fault, seen.fault);
		end
	endtask

	// result side: own stall pattern, plus one long hold-off on request
	initial begin : result_side
		rx_mode_t mode;
		int       mode_left;
		int       hold_left;
		bit       got;
		res_t     seen;
		mode = RX_FLOW;
		mode_left = 0;
		hold_left = 0;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			got = res_ch.valid && res_ch.ready;
			seen = res_t'{res_ch.up_valve, res_ch.down_valve, res_ch.busy_res,
				fault_t'(res_ch.fault)};
			@(posedge clk);
			if (got) check_result(seen);
			if (hold_off_req && hold_left == 0) begin
				hold_left = 80;
				hold_off_req = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(10, 80);
				end
				mode_left--;
				case (mode)
					RX_FLOW: res_ch.ready <= 1'b1;
					RX_COIN: res_ch.ready <= 1'($urandom);
					default: res_ch.ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		step_row_t   dir_rows[$];
		wheel_item_t c;
		cfg_t        v;
		res_t        idle_res;
		int          p;
		int          n_phase;
		int          run_len;
		int          aim;
		bit          hold_armed;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.func = 1'b0;
		cmd_ch.cmd_kind = ACT_STOP;
		cmd_ch.has_target = 1'b0;
		cmd_ch.target_level = '0;
		cmd_ch.has_timeout = 1'b0;
		cmd_ch.timeout_sec = '0;
		cmd_ch.sample_valid = 1'b0;
		cmd_ch.level_sample = '0;
		cmd_ch.delta_valid = 1'b0;
		cmd_ch.avg_delta = '0;
		cmd_ch.second_tick = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_LEVEL_MAX;
		cfg_ch.data = '0;
		regs = '{LEVEL_MAX_RST, LEVEL_MIN_RST, DEAD_BAND_RST, DEV_MIN_RST, DEF_TIMEOUT_RST};
		wheel_running = 1'b0;
		wheel_action = ACT_UNKNOWN;
		wheel_goal = 8'd0;
		run_secs = 8'd0;
		run_limit = 8'd0;
		valve_bits = 2'b00;
		idle_res = res_t'{1'b0, 1'b0, 1'b0, FLT_NONE};
		hold_armed = 1'b0;
		aim = 128;

		// idle, manual up/down, limits, zero timeout, unknown command, missing inputs,
		// auto mode at the range ends, low deviation, goal inside the dead band
		dir_rows.push_back('{cyc(0, ACT_STOP, 0, 0, 0, 0, 1, 0, 0, 0, 1), 1'b1, idle_res});
		dir_rows.push_back('{cyc(1, ACT_UP, 0, 0, 0, 0, 1, 100, 1, 0, 0), 1'b1,
			res_t'{1'b1, 1'b0, 1'b1, FLT_NONE}});
		dir_rows.push_back('{cyc(0, ACT_UP, 0, 0, 0, 0, 1, 255, 0, 0, 1), 1'b1,
			res_t'{1'b0, 1'b0, 1'b1, FLT_NONE}});
		dir_rows.push_back('{cyc(1, ACT_DOWN, 0, 0, 1, 0, 1, 100, 0, 0, 0), 1'b1, idle_res});
		dir_rows.push_back('{cyc(1, ACT_UNKNOWN, 0, 0, 0, 0, 1, 100, 1, 100, 0), 1'b1,
			res_t'{1'b0, 1'b0, 1'b1, FLT_UNKNOWN_CMD}});
		dir_rows.push_back('{cyc(0, ACT_UP, 0, 0, 0, 0, 0, 100, 1, 100, 0), 1'b1,
			res_t'{1'b0, 1'b0, 1'b0, FLT_NO_SAMPLE}});
		dir_rows.push_back('{cyc(1, ACT_DOWN, 1, 255, 1, 255, 1, 0, 0, 255, 0), 1'b1,
			res_t'{1'b0, 1'b0, 1'b0, FLT_NO_AVG}});
		dir_rows.push_back('{cyc(1, ACT_UP, 1, 255, 1, 255, 1, 0, 1, 255, 1), 1'b1,
			res_t'{1'b1, 1'b0, 1'b1, FLT_NONE}});
		dir_rows.push_back('{cyc(0, ACT_UP, 0, 0, 0, 0, 1, 255, 1, 255, 1), 1'b1,
			res_t'{1'b0, 1'b0, 1'b1, FLT_NONE}});
		dir_rows.push_back('{cyc(0, ACT_UP, 0, 0, 0, 0, 1, 128, 1, 0, 0), 1'b1, idle_res});
		dir_rows.push_back('{cyc(1, ACT_STOP, 1, 3, 0, 0, 1, 0, 1, 4, 0), 1'b0, idle_res});
		dir_rows.push_back('{cyc(1, ACT_UP, 1, 0, 0, 0, 1, 50, 0, 0, 0), 1'b0, idle_res});
		dir_rows.push_back('{cyc(1, ACT_UNKNOWN, 0, 0, 0, 0, 1, 50, 0, 0, 0), 1'b0, idle_res});
		dir_rows.push_back('{cyc(0, ACT_DOWN, 0, 0, 0, 0, 1, 50, 0, 0, 1), 1'b0, idle_res});
		dir_rows.push_back('{cyc(1, ACT_DOWN, 0, 0, 1, 1, 1, 0, 0, 0, 0), 1'b0, idle_res});
		dir_rows.push_back('{cyc(0, ACT_DOWN, 0, 0, 0, 0, 1, 0, 0, 0, 1), 1'b0, idle_res});
		dir_rows.push_back('{cyc(1, ACT_DOWN, 1, 100, 1, 2, 1, 200, 1, 100, 0), 1'b0, idle_res});
		dir_rows.push_back('{cyc(0, ACT_UP, 0, 0, 0, 0, 1, 255, 1, 100, 1), 1'b0, idle_res});
		dir_rows.push_back('{cyc(0, ACT_UP, 0, 0, 0, 0, 1, 255, 1, 100, 1), 1'b0, idle_res});
		dir_rows.push_back('{cyc(1, ACT_UP, 1, 255, 1, 255, 1, 255, 1, 255, 1), 1'b0, idle_res});
		dir_rows.push_back('{cyc(1, ACT_STOP, 0, 255, 0, 255, 1, 0, 1, 0, 0), 1'b0, idle_res});

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) offer_cycle(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

		for (p = 0; p < 6; p++) begin
			settle();
			case (p)
				1: v = '{8'd0, 8'd255, 8'd0, 8'd0, 8'd0};
				2: v = '{8'd255, 8'd0, 8'd255, 8'd255, 8'd255};
				3: v = '{LEVEL_MAX_RST, LEVEL_MIN_RST, DEAD_BAND_RST, DEV_MIN_RST,
					DEF_TIMEOUT_RST};
				5: v = cfg_t'({$urandom, 8'($urandom)});
				default: v = '{8'($urandom_range(180, 255)), 8'($urandom_range(0, 60)),
					8'($urandom_range(0, 12)), 8'($urandom_range(0, 10)),
					8'($urandom_range(0, 30))};
			endcase
			load_regs(v);
			n_phase = 0;
			while (n_phase < 228) begin
				if (!hold_armed && n_items >= 400) begin
					hold_off_req = 1'b1;
					hold_armed = 1'b1;
				end
				if ($urandom_range(0, 9) == 0) begin
					c = rand_cycle(128);
					c.func = 1'($urandom);
					c.sample_valid = 1'($urandom);
					c.delta_valid = 1'($urandom);
					c.level_sample = 8'($urandom);
					offer_cycle(c, 1'b0, idle_res);
					n_phase++;
				end else begin
					c = rand_cycle(aim);
					c.func = 1'b1;
					c.cmd_kind = ($urandom_range(0, 15) == 0) ? ACT_UNKNOWN :
						2'($urandom_range(0, 2));
					c.has_target = ($urandom_range(0, 2) != 0);
					c.target_level = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
						8'($urandom_range(16, 240));
					c.has_timeout = 1'($urandom);
					c.timeout_sec = ($urandom_range(0, 7) == 0) ? 8'($urandom) :
						8'($urandom_range(0, 12));
					if (c.has_target) aim = c.target_level;
					offer_cycle(c, 1'b0, idle_res);
					n_phase++;
					run_len = $urandom_range(0, 24);
					repeat (run_len) begin
						offer_cycle(rand_cycle(aim), 1'b0, idle_res);
						n_phase++;
					end
				end
			end
		end

		settle();
		repeat (8) @(posedge clk);
		$display("covered %0d items (%0d commands) under reset and 6 register settings",
			n_items, n_cmds);
		$display("%0d results checked, %0d reported a fault", n_checked, n_faulted);
		if (errors == 0 && pending_res.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
